/* src/ordered_list_store_macros.svh */
// ----------------------------------------------------------------------------
// ordered_list_store assertion macros
// Clocked, reset-gated assertion shorthands for the ordered list store.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_STORE_MACROS_SVH
`define ORDERED_LIST_STORE_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define OLS_CHECK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define OLS_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/ols_pkg.sv */
// ----------------------------------------------------------------------------
// ols_pkg
// Item types and request / status codes of the ordered list store.
// ----------------------------------------------------------------------------
`default_nettype none

package ols_pkg;

    localparam logic [2:0] MODE_APPEND      = 3'd0;
    localparam logic [2:0] MODE_REMOVE_LAST = 3'd1;
    localparam logic [2:0] MODE_INSERT      = 3'd2;
    localparam logic [2:0] MODE_ERASE_VALUE = 3'd3;
    localparam logic [2:0] MODE_ERASE_RANGE = 3'd4;
    localparam logic [2:0] MODE_CLEAR       = 3'd5;
    localparam logic [2:0] MODE_READ        = 3'd6;
    localparam logic [2:0] MODE_FILL        = 3'd7;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_RANGE    = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    typedef struct packed {
        logic [2:0]  mode;
        logic [6:0]  position;
        logic [5:0]  position_end;
        logic [31:0] item_value;
        logic [6:0]  fill_count;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] read_value;
        logic [6:0]  list_length;
    } rsp_t;

endpackage

`default_nettype wire

/* src/ols_ram.sv */
// ----------------------------------------------------------------------------
// ols_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ols_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* src/ordered_list_store.sv */
// ----------------------------------------------------------------------------
// ordered_list_store
// Fixed-capacity ordered list of words with append, remove, insert, erase,
// read, clear and fill requests, one result per request.
// ----------------------------------------------------------------------------
//
//  channel   signals                     direction   payload
//  --------  --------------------------  ---------   -------------------
//  request   req_valid / req_ready / req  in          ols_pkg::req_t
//  result    rsp_valid / rsp_ready / rsp  out         ols_pkg::rsp_t
//
//  Append, remove last, clear and requests rejected at decode go from decode
//  straight to done; read passes a read state first. Insert, erase and fill
//  move one entry per cycle through the RAM's single read / write port pair;
//  an erase by value first scans the list for the first match.
//  Reset empties the list at once; no clearing pass, entries are undefined.
//  A finished result waits in the output register; the next request is taken
//  while it waits, and only the final step stalls on a full output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_store #(
    parameter int CAPACITY   = 64,
    parameter int WORD_WIDTH = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire ols_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output ols_pkg::rsp_t      rsp
);

    import ols_pkg::*;

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = (LW > 7) ? LW : 7;
    localparam logic [CW-1:0] CAP_W = CW'(CAPACITY);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECODE = 8'b0000_0010,
        S_SCAN   = 8'b0000_0100,
        S_COPY   = 8'b0000_1000,
        S_INSERT = 8'b0001_0000,
        S_FILL   = 8'b0010_0000,
        S_READ   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    // control
    state_t          state_reg, state_next;
    logic [LW-1:0]   fill_reg, fill_next;
    logic            rsp_valid_reg, rsp_valid_next;
    logic            pend_reg, pend_next;
    logic            cmp_vld_reg, cmp_vld_next;

    // payload / datapath
    req_t            req_reg, req_next;
    rsp_t            rsp_reg, rsp_next;
    logic [2:0]      status_reg, status_next;
    logic [31:0]     rd_val_reg, rd_val_next;
    logic [LW-1:0]   src_reg, src_next;
    logic [LW-1:0]   dst_reg, dst_next;
    logic [LW-1:0]   copy_cnt_reg, copy_cnt_next;
    logic            dir_up_reg, dir_up_next;
    logic [LW-1:0]   scan_ptr_reg, scan_ptr_next;
    logic [LW-1:0]   cmp_idx_reg, cmp_idx_next;
    logic [LW-1:0]   fill_ptr_reg, fill_ptr_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [WORD_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [WORD_WIDTH-1:0] ram_rdata;

    logic [CW-1:0]         pos_w, pend_w, fill_w, cnt_w;
    logic [WORD_WIDTH-1:0] val_w;

    assign pos_w  = CW'(req_reg.position);
    assign pend_w = CW'(req_reg.position_end);
    assign fill_w = CW'(fill_reg);
    assign cnt_w  = CW'(req_reg.fill_count);
    assign val_w  = WORD_WIDTH'(req_reg.item_value);

    ols_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        pend_next      = 1'b0;
        cmp_vld_next   = 1'b0;
        req_next       = req_reg;
        rsp_next       = rsp_reg;
        status_next    = status_reg;
        rd_val_next    = rd_val_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        copy_cnt_next  = copy_cnt_reg;
        dir_up_next    = dir_up_reg;
        scan_ptr_next  = scan_ptr_reg;
        cmp_idx_next   = cmp_idx_reg;
        fill_ptr_next  = fill_ptr_reg;
        ram_we         = 1'b0;
        ram_waddr      = AW'(dst_reg);
        ram_wdata      = val_w;
        ram_raddr      = AW'(src_reg);
        req_ready      = (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next    = req;
                    status_next = ST_OK;
                    rd_val_next = '0;
                    state_next  = S_DECODE;
                end
            end

            S_DECODE:
            begin
                state_next = S_DONE;
                case (req_reg.mode)
                    MODE_APPEND:
                    begin
                        if (fill_w >= CAP_W)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = AW'(fill_reg);
                            fill_next = fill_reg + 1'b1;
                        end
                    end
                    MODE_REMOVE_LAST:
                    begin
                        if (fill_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            fill_next = fill_reg - 1'b1;
                        end
                    end
                    MODE_INSERT:
                    begin
                        if (pos_w > fill_w)
                        begin
                            status_next = ST_RANGE;
                        end
                        else if (fill_w >= CAP_W)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            // shift the tail up by one, top entry first
                            src_next      = LW'(fill_w - 1'b1);
                            dst_next      = fill_reg;
                            copy_cnt_next = LW'(fill_w - pos_w);
                            dir_up_next   = 1'b0;
                            state_next    = S_COPY;
                        end
                    end
                    MODE_ERASE_VALUE:
                    begin
                        scan_ptr_next = '0;
                        state_next    = S_SCAN;
                    end
                    MODE_ERASE_RANGE:
                    begin
                        if (pos_w > pend_w || pend_w >= fill_w)
                        begin
                            status_next = ST_RANGE;
                        end
                        else
                        begin
                            src_next      = LW'(pend_w + 1'b1);
                            dst_next      = LW'(pos_w);
                            copy_cnt_next = LW'(fill_w - pend_w - 1'b1);
                            dir_up_next   = 1'b1;
                            fill_next     = LW'(fill_w - (pend_w - pos_w + 1'b1));
                            state_next    = S_COPY;
                        end
                    end
                    MODE_CLEAR:
                    begin
                        fill_next = '0;
                    end
                    MODE_READ:
                    begin
                        if (pos_w >= fill_w)
                        begin
                            status_next = ST_RANGE;
                        end
                        else
                        begin
                            ram_raddr  = AW'(req_reg.position);
                            state_next = S_READ;
                        end
                    end
                    MODE_FILL:
                    begin
                        if (cnt_w > CAP_W)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            fill_ptr_next = '0;
                            fill_next     = LW'(cnt_w);
                            state_next    = S_FILL;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_SCAN:
            begin
                // compare lags the read address by the RAM's read register
                if (cmp_vld_reg && ram_rdata == val_w)
                begin
                    src_next      = cmp_idx_reg + 1'b1;
                    dst_next      = cmp_idx_reg;
                    copy_cnt_next = fill_reg - cmp_idx_reg - 1'b1;
                    dir_up_next   = 1'b1;
                    fill_next     = fill_reg - 1'b1;
                    state_next    = S_COPY;
                end
                else if (scan_ptr_reg < fill_reg)
                begin
                    ram_raddr     = AW'(scan_ptr_reg);
                    scan_ptr_next = scan_ptr_reg + 1'b1;
                    cmp_vld_next  = 1'b1;
                    cmp_idx_next  = scan_ptr_reg;
                end
                else if (!cmp_vld_reg)
                begin
                    status_next = ST_NOTFOUND;
                    state_next  = S_DONE;
                end
            end

            S_COPY:
            begin
                // read one entry ahead, write the one read last cycle
                if (copy_cnt_reg != '0)
                begin
                    ram_raddr     = AW'(src_reg);
                    src_next      = dir_up_reg ? src_reg + 1'b1 : src_reg - 1'b1;
                    copy_cnt_next = copy_cnt_reg - 1'b1;
                    pend_next     = 1'b1;
                end
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(dst_reg);
                    ram_wdata = ram_rdata;
                    dst_next  = dir_up_reg ? dst_reg + 1'b1 : dst_reg - 1'b1;
                end
                if (copy_cnt_reg == '0 && !pend_reg)
                begin
                    state_next = (req_reg.mode == MODE_INSERT) ? S_INSERT : S_DONE;
                end
            end

            S_INSERT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(req_reg.position);
                fill_next  = fill_reg + 1'b1;
                state_next = S_DONE;
            end

            S_FILL:
            begin
                if (CW'(fill_ptr_reg) < cnt_w)
                begin
                    ram_we        = 1'b1;
                    ram_waddr     = AW'(fill_ptr_reg);
                    fill_ptr_next = fill_ptr_reg + 1'b1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_READ:
            begin
                rd_val_next = 32'(ram_rdata);
                state_next  = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.status      = status_reg;
                    rsp_next.read_value  = rd_val_reg;
                    rsp_next.list_length = 7'(fill_reg);
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            cmp_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            rsp_valid_reg <= rsp_valid_next;
            pend_reg      <= pend_next;
            cmp_vld_reg   <= cmp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        rsp_reg      <= rsp_next;
        status_reg   <= status_next;
        rd_val_reg   <= rd_val_next;
        src_reg      <= src_next;
        dst_reg      <= dst_next;
        copy_cnt_reg <= copy_cnt_next;
        dir_up_reg   <= dir_up_next;
        scan_ptr_reg <= scan_ptr_next;
        cmp_idx_reg  <= cmp_idx_next;
        fill_ptr_reg <= fill_ptr_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`include "ordered_list_store_macros.svh"

    `OLS_CHECK(a_fill_bound, fill_reg <= CAPACITY, "list length above capacity")
    `OLS_CHECK_NEXT(a_accept_decode, req_valid && req_ready, state_reg == S_DECODE, "no decode")
    `OLS_CHECK(a_rsp_from_done, $rose(rsp_valid_reg) |-> $past(state_reg == S_DONE), "early result")

endmodule

`default_nettype wire

/* tb/ordered_list_store_test.sv */
// ----------------------------------------------------------------------------
// ordered_list_store_test
// Drives list requests into the ordered list store and checks every result
// against a behavioral list kept in the bench. A directed pass covers the
// empty and full list, shifting on insert and erase, range errors and fill
// limits. Random traffic then runs under three sender/receiver stall mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_store_test;
    import ols_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int WORD_WIDTH   = 32;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 200;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int error_count = 0;

    // bench copy of the list contents
    logic [31:0] list_words [CAPACITY];
    int          list_len = 0;
    rsp_t        expected_results [$];

    ordered_list_store #(
        .CAPACITY   (CAPACITY),
        .WORD_WIDTH (WORD_WIDTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        error_count++;
    endtask

    // Applies one request to the bench list and returns the result it should give.
    function automatic rsp_t apply_request(input req_t item);
        rsp_t outcome;
        int   i;
        int   at;
        int   gap;
        outcome = '0;
        outcome.status = ST_OK;
        case (item.mode)
            MODE_APPEND:
                if (list_len >= CAPACITY)
                    outcome.status = ST_FULL;
                else
                begin
                    list_words[list_len] = item.item_value;
                    list_len++;
                end
            MODE_REMOVE_LAST:
                if (list_len == 0)
                    outcome.status = ST_EMPTY;
                else
                    list_len--;
            MODE_INSERT:
                if (int'(item.position) > list_len)
                    outcome.status = ST_RANGE;
                else if (list_len >= CAPACITY)
                    outcome.status = ST_FULL;
                else
                begin
                    for (i = list_len; i > int'(item.position); i--)
                        list_words[i] = list_words[i - 1];
                    list_words[item.position] = item.item_value;
                    list_len++;
                end
            MODE_ERASE_VALUE:
            begin
                at = -1;
                for (i = 0; i < list_len && at < 0; i++)
                    if (list_words[i] == item.item_value)
                        at = i;
                if (at < 0)
                    outcome.status = ST_NOTFOUND;
                else
                begin
                    for (i = at; i + 1 < list_len; i++)
                        list_words[i] = list_words[i + 1];
                    list_len--;
                end
            end
            MODE_ERASE_RANGE:
                if (int'(item.position) > int'(item.position_end)
                    || int'(item.position_end) >= list_len)
                    outcome.status = ST_RANGE;
                else
                begin
                    gap = int'(item.position_end) - int'(item.position) + 1;
                    for (i = int'(item.position_end) + 1; i < list_len; i++)
                        list_words[i - gap] = list_words[i];
                    list_len -= gap;
                end
            MODE_CLEAR:
                list_len = 0;
            MODE_READ:
                if (int'(item.position) >= list_len)
                    outcome.status = ST_RANGE;
                else
                    outcome.read_value = list_words[item.position];
            MODE_FILL:
                if (int'(item.fill_count) > CAPACITY)
                    outcome.status = ST_FULL;
                else
                begin
                    for (i = 0; i < int'(item.fill_count); i++)
                        list_words[i] = item.item_value;
                    list_len = int'(item.fill_count);
                end
            default: ;
        endcase
        outcome.list_length = list_len[6:0];
        return outcome;
    endfunction

    always @(posedge clk)
    begin : result_check
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("unexpected result %p", rsp));
            else
            begin
                want = expected_results.pop_front();
                if (rsp.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              rsp.status, want.status));
                if (rsp.read_value !== want.read_value)
                    report_mismatch($sformatf("read_value %h, want %h",
                                              rsp.read_value, want.read_value));
                if (rsp.list_length !== want.list_length)
                    report_mismatch($sformatf("list_length %0d, want %0d",
                                              rsp.list_length, want.list_length));
            end
        end
    end

    // Valid stays high between back-to-back items; it drops only in sender gaps.
    task automatic send_request(input req_t item);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (!req_ready);
        expected_results = {expected_results, apply_request(item)};
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic req_t make_request(input logic [2:0] mode, input logic [6:0] position,
                                          input logic [5:0] position_end,
                                          input logic [31:0] value, input logic [6:0] count);
        req_t item;
        item.mode         = mode;
        item.position     = position;
        item.position_end = position_end;
        item.item_value   = value;
        item.fill_count   = count;
        return item;
    endfunction

    task automatic test_empty_list();
        send_request(make_request(MODE_REMOVE_LAST, 0, 0, 32'h0, 0));
        send_request(make_request(MODE_ERASE_VALUE, 0, 0, 32'h0, 0));
        send_request(make_request(MODE_READ, 0, 0, 32'h0, 0));
        send_request(make_request(MODE_ERASE_RANGE, 0, 0, 32'h0, 0));
        send_request(make_request(MODE_INSERT, 1, 0, 32'h1, 0));
    endtask

    task automatic test_insert_erase();
        send_request(make_request(MODE_INSERT, 0, 0, 32'h0000_0000, 0));
        send_request(make_request(MODE_APPEND, 0, 0, 32'hffff_ffff, 0));
        send_request(make_request(MODE_INSERT, 1, 0, 32'h1234_5678, 0));
        send_request(make_request(MODE_INSERT, 3, 0, 32'ha5a5_a5a5, 0));
        // duplicate at the tail: erase by value must take the first one
        send_request(make_request(MODE_APPEND, 0, 0, 32'h1234_5678, 0));
        send_request(make_request(MODE_ERASE_VALUE, 0, 0, 32'h1234_5678, 0));
        send_request(make_request(MODE_READ, 1, 0, 32'h0, 0));
        send_request(make_request(MODE_READ, 4, 0, 32'h0, 0));
        send_request(make_request(MODE_ERASE_VALUE, 0, 0, 32'hdead_beef, 0));
        send_request(make_request(MODE_ERASE_RANGE, 2, 1, 32'h0, 0));
        send_request(make_request(MODE_ERASE_RANGE, 1, 4, 32'h0, 0));
        send_request(make_request(MODE_ERASE_RANGE, 0, 3, 32'h0, 0));
    endtask

    task automatic test_full_list();
        send_request(make_request(MODE_FILL, 0, 0, 32'h5a5a_5a5a, 7'd64));
        send_request(make_request(MODE_APPEND, 0, 0, 32'h1, 0));
        send_request(make_request(MODE_INSERT, 7'd64, 0, 32'h2, 0));
        // out of range wins over full
        send_request(make_request(MODE_INSERT, 7'd65, 0, 32'h3, 0));
        send_request(make_request(MODE_READ, 7'd63, 0, 32'h0, 0));
        send_request(make_request(MODE_FILL, 0, 0, 32'h4, 7'd127));
        send_request(make_request(MODE_FILL, 0, 0, 32'h5, 7'd65));
        send_request(make_request(MODE_ERASE_RANGE, 0, 6'd63, 32'h0, 0));
        send_request(make_request(MODE_CLEAR, 0, 0, 32'h0, 0));
    endtask

    // Mostly well-formed requests aimed at the current list; a few are pure noise.
    function automatic req_t random_request();
        req_t item;
        int   pick;
        int   lo;
        int   hi;
        item.mode         = 3'($urandom);
        item.position     = 7'($urandom);
        item.position_end = 6'($urandom);
        item.item_value   = $urandom;
        item.fill_count   = 7'($urandom);
        case ($urandom_range(0, 3))
            0: item.item_value = $urandom_range(0, 7);
            1: item.item_value = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
            default: ;
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 4)
            return item;
        if (pick < 28)
            item.mode = MODE_APPEND;
        else if (pick < 42)
        begin
            item.mode = MODE_INSERT;
            if ($urandom_range(0, 9) != 0)
                item.position = 7'($urandom_range(0, list_len));
        end
        else if (pick < 52)
            item.mode = MODE_REMOVE_LAST;
        else if (pick < 64)
        begin
            item.mode = MODE_ERASE_VALUE;
            if (list_len > 0 && $urandom_range(0, 3) != 0)
                item.item_value = list_words[$urandom_range(0, list_len - 1)];
        end
        else if (pick < 74)
        begin
            item.mode = MODE_ERASE_RANGE;
            if (list_len > 0 && $urandom_range(0, 4) != 0)
            begin
                lo = $urandom_range(0, list_len - 1);
                hi = (lo + 7 < list_len - 1) ? lo + 7 : list_len - 1;
                item.position     = 7'(lo);
                item.position_end = 6'($urandom_range(lo, hi));
            end
        end
        else if (pick < 88)
        begin
            item.mode = MODE_READ;
            if (list_len > 0 && $urandom_range(0, 4) != 0)
                item.position = 7'($urandom_range(0, list_len - 1));
        end
        else if (pick < 96)
        begin
            item.mode = MODE_FILL;
            if ($urandom_range(0, 4) != 0)
                item.fill_count = 7'($urandom_range(0, CAPACITY));
        end
        else
            item.mode = MODE_CLEAR;
        return item;
    endfunction

    task automatic test_random(input int count, input int tx_pct, input int rx_pct);
        int n;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (n = 0; n < count; n++)
        begin
            // hold the sender once per phase until the block has drained
            if (n == count / 2)
                wait_drained();
            send_request(random_request());
        end
    endtask

    initial
    begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        tx_idle_pct = 20;
        rx_idle_pct = 57;
        test_empty_list();
        test_insert_erase();
        test_full_list();
        test_random(210, 20, 57);
        test_random(210, 57, 20);
        test_random(210, 0, 0);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
